/* design/ddtw_pkg.sv */
package ddtw_pkg;

    // Field widths
    localparam int SPD_W  = 32;
    localparam int RAD_W  = 20;
    localparam int TRK_W  = 24;
    localparam int TCK_W  = 24;
    localparam int LIM_W  = 31;
    localparam int CFG_W  = 31;

    // Derived datapath widths
    localparam int TPI_W  = 35;            // 2*pi in Q32
    localparam int DEN_W  = TPI_W + RAD_W; // 2*pi*radius, Q32
    localparam int CAP_W  = DEN_W + LIM_W; // den * limit
    localparam int MAG_W  = 56;            // |v*2e6 -/+ w*track|
    localparam int N_W    = MAG_W + TCK_W; // |a| * ticks
    localparam int PROD_W = N_W + LIM_W;   // n * limit
    localparam int DNUM_W = PROD_W + 1;    // divider numerator
    localparam int DDEN_W = N_W + 1;       // divider denominator
    localparam int QUO_W  = 32;            // quotient bits

    localparam logic [20:0]      SPD_SCALE  = 21'd2000000;
    localparam logic [TPI_W-1:0] TWO_PI_Q32 = 35'd26986075409;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_TRACK  = 2'd1,
        REG_TICKS  = 2'd2,
        REG_LIMIT  = 2'd3
    } reg_idx_t;

    // Geometry seen by the datapath
    typedef struct packed {
        logic [TRK_W-1:0] track;
        logic [TCK_W-1:0] ticks;
        logic [LIM_W-1:0] limit;
        logic [DEN_W-1:0] den;
        logic [CAP_W-1:0] cap;
        logic             sane;
    } geom_t;

    typedef struct packed {
        logic             ok;
        logic [SPD_W-1:0] left_rate;
        logic [SPD_W-1:0] right_rate;
    } rate_t;

endpackage

/* design/ddtw_if.sv */
interface ddtw_cmd_if;
    import ddtw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] linear_speed;
    logic signed [SPD_W-1:0] yaw_rate;

    modport source (output valid, linear_speed, yaw_rate, input ready);
    modport sink   (input valid, linear_speed, yaw_rate, output ready);
endinterface

interface ddtw_rate_if;
    import ddtw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic signed [SPD_W-1:0] left_rate;
    logic signed [SPD_W-1:0] right_rate;

    modport source (output valid, ok, left_rate, right_rate, input ready);
    modport sink   (input valid, ok, left_rate, right_rate, output ready);
endinterface

/* design/diff_drive_twist_to_wheel_rate.sv */
// Differential drive inverse kinematics. Takes a body twist (Q16.16 m/s and
// Q16.16 rad/s) and returns left and right wheel tick rates, scaled together
// when either would pass rate_limit, rounded half away from zero and clamped.
// ok is low and both rates are zero while any geometry register is zero.
// Throughput is one item per clock while the skid stage is empty. An item
// passes nine arithmetic stages, a 33-stage bit-per-stage divider for each
// wheel and the output register. A skid stage holds one extra result so
// output stalls back-pressure the input cleanly. Geometry must be written
// over the cfg port only while no item is in flight; nothing enforces it.
module diff_drive_twist_to_wheel_rate (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  ddtw_pkg::reg_idx_t          cfg_idx,
    input  logic [ddtw_pkg::CFG_W-1:0]  cfg_data,
    ddtw_cmd_if.sink                    cmd,
    ddtw_rate_if.source                 rate
);
    import ddtw_pkg::*;

    logic [RAD_W-1:0] radius_reg;
    logic [TRK_W-1:0] track_reg;
    logic [TCK_W-1:0] ticks_reg;
    logic [LIM_W-1:0] limit_reg;
    logic [DEN_W-1:0] den_reg;
    logic [58:0]      cap_lo_reg;
    logic [57:0]      cap_hi_reg;
    logic [CAP_W-1:0] cap_reg;
    geom_t            geom;

    logic              en;
    logic              f_valid, f_lneg, f_rneg;
    logic [DNUM_W-1:0] f_lnum, f_rnum;
    logic [DDEN_W-1:0] f_den;
    logic              l_valid, r_valid, l_neg, r_neg;
    logic [QUO_W-1:0]  l_quo, r_quo;
    rate_t             res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            track_reg  <= '0;
            ticks_reg  <= '0;
            limit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                REG_TRACK:  track_reg  <= cfg_data[TRK_W-1:0];
                REG_TICKS:  ticks_reg  <= cfg_data[TCK_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[LIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // derived geometry: 2*pi*radius and its product with the limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            den_reg    <= '0;
            cap_lo_reg <= '0;
            cap_hi_reg <= '0;
            cap_reg    <= '0;
        end
        else
        begin
            den_reg    <= TWO_PI_Q32 * radius_reg;
            cap_lo_reg <= den_reg[27:0] * limit_reg;
            cap_hi_reg <= den_reg[54:28] * limit_reg;
            cap_reg    <= {cap_hi_reg, 28'd0} + {27'd0, cap_lo_reg};
        end
    end

    always_comb
    begin
        geom.track = track_reg;
        geom.ticks = ticks_reg;
        geom.limit = limit_reg;
        geom.den   = den_reg;
        geom.cap   = cap_reg;
        geom.sane  = (radius_reg != '0) && (track_reg != '0) &&
                     (ticks_reg != '0) && (limit_reg != '0);
    end

    assign cmd.ready = en;

    ddtw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (cmd.valid),
        .linear_speed (cmd.linear_speed),
        .yaw_rate     (cmd.yaw_rate),
        .g            (geom),
        .out_valid    (f_valid),
        .l_neg        (f_lneg),
        .r_neg        (f_rneg),
        .l_num        (f_lnum),
        .r_num        (f_rnum),
        .div_den      (f_den)
    );

    ddtw_div #(.NW(DNUM_W), .DW(DDEN_W), .QW(QUO_W)) u_div_l (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_neg    (f_lneg),
        .num       (f_lnum),
        .den       (f_den),
        .out_valid (l_valid),
        .out_neg   (l_neg),
        .quo       (l_quo)
    );

    ddtw_div #(.NW(DNUM_W), .DW(DDEN_W), .QW(QUO_W)) u_div_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_neg    (f_rneg),
        .num       (f_rnum),
        .den       (f_den),
        .out_valid (r_valid),
        .out_neg   (r_neg),
        .quo       (r_quo)
    );

    ddtw_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l_valid && r_valid),
        .l_neg     (l_neg),
        .r_neg     (r_neg),
        .l_quo     (l_quo),
        .r_quo     (r_quo),
        .g         (geom),
        .out_ready (rate.ready),
        .en        (en),
        .out_valid (rate.valid),
        .out_data  (res)
    );

    assign rate.ok         = res.ok;
    assign rate.left_rate  = res.left_rate;
    assign rate.right_rate = res.right_rate;

endmodule

/* design/ddtw_front.sv */
module ddtw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ddtw_pkg::SPD_W-1:0]    linear_speed,
    input  logic [ddtw_pkg::SPD_W-1:0]    yaw_rate,
    input  ddtw_pkg::geom_t               g,
    output logic                          out_valid,
    output logic                          l_neg,
    output logic                          r_neg,
    output logic [ddtw_pkg::DNUM_W-1:0]   l_num,
    output logic [ddtw_pkg::DNUM_W-1:0]   r_num,
    output logic [ddtw_pkg::DDEN_W-1:0]   div_den
);
    import ddtw_pkg::*;

    localparam int STAGES = 9;

    logic [STAGES-1:0] vld_reg;

    // s1
    logic [SPD_W-1:0] v1_reg, w1_reg;
    // s2
    logic signed [53:0] mv2_reg;
    logic signed [56:0] mw2_reg;
    // s3
    logic [57:0]      al_c, ar_c;
    logic [57:0]      alabs_c, arabs_c;
    logic [MAG_W-1:0] al3_reg, ar3_reg;
    logic             nl3_reg, nr3_reg;
    // s4
    logic [51:0] pl_lo4_reg, pl_hi4_reg, pr_lo4_reg, pr_hi4_reg;
    logic        nl4_reg, nr4_reg;
    // s5
    logic [N_W-1:0] nl5_reg, nr5_reg;
    logic           sl5_reg, sr5_reg;
    // s6
    logic [N_W-1:0] peak_c;
    logic [N_W-1:0] nl6_reg, nr6_reg, pk6_reg;
    logic           sl6_reg, sr6_reg, sc6_reg;
    // s7
    logic [57:0]    ql0_reg, ql1_reg, qr0_reg, qr1_reg;
    logic [56:0]    ql2_reg, qr2_reg;
    logic [N_W-1:0] nl7_reg, nr7_reg, pk7_reg;
    logic           sl7_reg, sr7_reg, sc7_reg;
    // s8
    logic [PROD_W-1:0] prl8_reg, prr8_reg;
    logic [N_W-1:0]    nl8_reg, nr8_reg, pk8_reg;
    logic              sl8_reg, sr8_reg, sc8_reg;
    // s9
    logic [DNUM_W-1:0] numl9_reg, numr9_reg;
    logic [DDEN_W-1:0] den9_reg;
    logic              sl9_reg, sr9_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // surface speeds, signs and magnitudes
    always_comb
    begin
        al_c    = {{4{mv2_reg[53]}}, mv2_reg} - {mw2_reg[56], mw2_reg};
        ar_c    = {{4{mv2_reg[53]}}, mv2_reg} + {mw2_reg[56], mw2_reg};
        alabs_c = al_c[57] ? (58'd0 - al_c) : al_c;
        arabs_c = ar_c[57] ? (58'd0 - ar_c) : ar_c;
        peak_c  = (nl5_reg >= nr5_reg) ? nl5_reg : nr5_reg;
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg <= linear_speed;
            w1_reg <= yaw_rate;

            mv2_reg <= $signed(v1_reg) * $signed({1'b0, SPD_SCALE});
            mw2_reg <= $signed(w1_reg) * $signed({1'b0, g.track});

            al3_reg <= alabs_c[MAG_W-1:0];
            ar3_reg <= arabs_c[MAG_W-1:0];
            nl3_reg <= al_c[57];
            nr3_reg <= ar_c[57];

            pl_lo4_reg <= al3_reg[27:0] * g.ticks;
            pl_hi4_reg <= al3_reg[55:28] * g.ticks;
            pr_lo4_reg <= ar3_reg[27:0] * g.ticks;
            pr_hi4_reg <= ar3_reg[55:28] * g.ticks;
            nl4_reg    <= nl3_reg;
            nr4_reg    <= nr3_reg;

            nl5_reg <= {pl_hi4_reg, 28'd0} + {28'd0, pl_lo4_reg};
            nr5_reg <= {pr_hi4_reg, 28'd0} + {28'd0, pr_lo4_reg};
            sl5_reg <= nl4_reg;
            sr5_reg <= nr4_reg;

            // scale both wheels when the peak tick rate passes the limit
            nl6_reg <= nl5_reg;
            nr6_reg <= nr5_reg;
            pk6_reg <= peak_c;
            sc6_reg <= {peak_c, 15'd0} > {9'd0, g.cap};
            sl6_reg <= sl5_reg;
            sr6_reg <= sr5_reg;

            ql0_reg <= nl6_reg[26:0] * g.limit;
            ql1_reg <= nl6_reg[53:27] * g.limit;
            ql2_reg <= nl6_reg[79:54] * g.limit;
            qr0_reg <= nr6_reg[26:0] * g.limit;
            qr1_reg <= nr6_reg[53:27] * g.limit;
            qr2_reg <= nr6_reg[79:54] * g.limit;
            nl7_reg <= nl6_reg;
            nr7_reg <= nr6_reg;
            pk7_reg <= pk6_reg;
            sc7_reg <= sc6_reg;
            sl7_reg <= sl6_reg;
            sr7_reg <= sr6_reg;

            prl8_reg <= {ql2_reg, 54'd0} + {26'd0, ql1_reg, 27'd0} + {53'd0, ql0_reg};
            prr8_reg <= {qr2_reg, 54'd0} + {26'd0, qr1_reg, 27'd0} + {53'd0, qr0_reg};
            nl8_reg  <= nl7_reg;
            nr8_reg  <= nr7_reg;
            pk8_reg  <= pk7_reg;
            sc8_reg  <= sc7_reg;
            sl8_reg  <= sl7_reg;
            sr8_reg  <= sr7_reg;

            // round half up: (2*num + den) / (2*den)
            if (sc8_reg)
            begin
                numl9_reg <= {prl8_reg, 1'b0} + {32'd0, pk8_reg};
                numr9_reg <= {prr8_reg, 1'b0} + {32'd0, pk8_reg};
                den9_reg  <= {pk8_reg, 1'b0};
            end
            else
            begin
                numl9_reg <= {16'd0, nl8_reg, 16'd0} + {57'd0, g.den};
                numr9_reg <= {16'd0, nr8_reg, 16'd0} + {57'd0, g.den};
                den9_reg  <= {25'd0, g.den, 1'b0};
            end
            sl9_reg <= sl8_reg;
            sr9_reg <= sr8_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign l_neg     = sl9_reg;
    assign r_neg     = sr9_reg;
    assign l_num     = numl9_reg;
    assign r_num     = numr9_reg;
    assign div_den   = den9_reg;

endmodule

/* design/ddtw_div.sv */
module ddtw_div #(
    parameter int NW = ddtw_pkg::DNUM_W,
    parameter int DW = ddtw_pkg::DDEN_W,
    parameter int QW = ddtw_pkg::QUO_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic          in_neg,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          out_valid,
    output logic          out_neg,
    output logic [QW-1:0] quo
);
    // Restoring divider, one quotient bit per stage.
    // The quotient is known to fit in QW bits, so num >> QW < den.

    logic [QW:0]   vld_reg;
    logic          neg_reg [QW+1];
    logic [DW-1:0] rem_reg [QW+1];
    logic [DW-1:0] d_reg   [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    // load stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(num[NW-1:QW]);
            low_reg[0] <= num[QW-1:0];
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= in_neg;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[k-1], low_reg[k-1][QW-1]};
            diff  = trial - {1'b0, d_reg[k-1]};
            ge    = trial >= {1'b0, d_reg[k-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_neg   = neg_reg[QW];
    assign quo       = q_reg[QW];

endmodule

/* design/ddtw_out.sv */
module ddtw_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         l_neg,
    input  logic                         r_neg,
    input  logic [ddtw_pkg::QUO_W-1:0]   l_quo,
    input  logic [ddtw_pkg::QUO_W-1:0]   r_quo,
    input  ddtw_pkg::geom_t              g,
    input  logic                         out_ready,
    output logic                         en,
    output logic                         out_valid,
    output ddtw_pkg::rate_t              out_data
);
    import ddtw_pkg::*;

    logic [QUO_W-1:0] lim_c, lmag_c, rmag_c;
    rate_t            res_c;
    rate_t            out_reg, skid_reg;
    logic             out_v_reg, skid_v_reg;
    logic             take;

    // clamp to the limit, apply sign, zero out unset geometry
    always_comb
    begin
        lim_c  = {1'b0, g.limit};
        lmag_c = (l_quo > lim_c) ? lim_c : l_quo;
        rmag_c = (r_quo > lim_c) ? lim_c : r_quo;
        if (g.sane)
        begin
            res_c.ok         = 1'b1;
            res_c.left_rate  = l_neg ? (QUO_W'(0) - lmag_c) : lmag_c;
            res_c.right_rate = r_neg ? (QUO_W'(0) - rmag_c) : rmag_c;
        end
        else
        begin
            res_c = '0;
        end
    end

    assign en   = !skid_v_reg;
    assign take = !out_v_reg || out_ready;

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (take)
        begin
            out_v_reg  <= skid_v_reg || in_valid;
            skid_v_reg <= 1'b0;
        end
        else if (en && in_valid)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= skid_v_reg ? skid_reg : res_c;
        end
        else if (!skid_v_reg)
        begin
            skid_reg <= res_c;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

/* design/ddtw_chk.sv */
module ddtw_props (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  ddtw_pkg::reg_idx_t          cfg_idx,
    input  logic [ddtw_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        rate_valid,
    input  logic                        rate_ready,
    input  logic                        ok,
    input  logic [ddtw_pkg::SPD_W-1:0]  left_rate,
    input  logic [ddtw_pkg::SPD_W-1:0]  right_rate
);
    import ddtw_pkg::*;

    logic [3:0]       set_reg;
    logic [LIM_W-1:0] lim_reg;
    logic signed [SPD_W-1:0] lim_s;

    // shadow of the geometry as written on the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg <= '0;
            lim_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_RADIUS: set_reg[0] <= cfg_data[RAD_W-1:0] != '0;
                REG_TRACK:  set_reg[1] <= cfg_data[TRK_W-1:0] != '0;
                REG_TICKS:  set_reg[2] <= cfg_data[TCK_W-1:0] != '0;
                REG_LIMIT:
                begin
                    set_reg[3] <= cfg_data[LIM_W-1:0] != '0;
                    lim_reg    <= cfg_data[LIM_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign lim_s = $signed({1'b0, lim_reg});

    // a stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid && !rate_ready |=> rate_valid && $stable(left_rate) &&
        $stable(right_rate) && $stable(ok))
        else $error("result changed while stalled");

    // unset geometry gives zero rates
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid && !ok |-> left_rate == '0 && right_rate == '0)
        else $error("nonzero rate with ok low");

    // ok follows the programmed geometry
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid |-> ok == (set_reg == 4'hF))
        else $error("ok does not match geometry");

    // rates stay inside the limit
    a_lim: assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid && ok |-> $signed(left_rate) <= lim_s &&
        $signed(left_rate) >= -lim_s && $signed(right_rate) <= lim_s &&
        $signed(right_rate) >= -lim_s)
        else $error("rate beyond limit");

endmodule

bind diff_drive_twist_to_wheel_rate ddtw_props u_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .rate_valid (rate.valid),
    .rate_ready (rate.ready),
    .ok         (rate.ok),
    .left_rate  (rate.left_rate),
    .right_rate (rate.right_rate)
);
